// ===== rtl/pdw_pkg.sv =====
package pdw_pkg;

    localparam int PATH_DEPTH = 64;
    localparam int ADDR_W     = $clog2(PATH_DEPTH);
    localparam int CNT_W      = $clog2(PATH_DEPTH + 1);

    localparam int COORD_W  = 32;
    localparam int DIST_W   = 31;
    localparam int POINT_W  = 3 * COORD_W;
    localparam int MAG_W    = COORD_W;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int SUMSQ_W  = PROD_W + 2;
    localparam int LEN_W    = SUMSQ_W / 2;

    localparam int MUL_STEPS  = MAG_W;
    localparam int ROOT_STEPS = LEN_W;
    localparam int DIV_STEPS  = PROD_W;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_QUERY   = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEG_CHECK,
        ST_RD_P0,
        ST_RD_P1,
        ST_DIFF,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_DECIDE,
        ST_I_MUL_GO,
        ST_I_MUL_WAIT,
        ST_I_DIV_GO,
        ST_I_DIV_WAIT,
        ST_WB,
        ST_Q_CHECK,
        ST_Q_ISSUE,
        ST_Q_LOAD,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/pdw_if.sv =====
interface pdw_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        command;
    logic                              first_point;
    logic signed [pdw_pkg::COORD_W-1:0] point_x;
    logic signed [pdw_pkg::COORD_W-1:0] point_y;
    logic signed [pdw_pkg::COORD_W-1:0] point_z;
    logic [pdw_pkg::DIST_W-1:0]        step_distance;

    modport source (output valid, command, first_point, point_x, point_y, point_z,
                    step_distance, input ready);
    modport sink   (input valid, command, first_point, point_x, point_y, point_z,
                    step_distance, output ready);
endinterface

interface pdw_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [pdw_pkg::COORD_W-1:0] pos_x;
    logic signed [pdw_pkg::COORD_W-1:0] pos_y;
    logic signed [pdw_pkg::COORD_W-1:0] pos_z;
    logic                              arrived;
    logic                              none_left;
    logic                              last;

    modport source (output valid, pos_x, pos_y, pos_z, arrived, none_left, last,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, arrived, none_left, last,
                     output ready);
endinterface

// ===== rtl/polyline_distance_walker.sv =====
// A load gives no output word; a query gives one word for each point still ahead, or a single
// none-left word. An advance gives one word, either at the path end or where it stops inside a
// segment; a segment costs three squarings, a root and its reads and compare, an interpolation
// three product and quotient pairs. The block takes one command at a time.
// Synchronous active-low reset empties the path and zeroes the last position.
module polyline_distance_walker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pdw_in_if.sink     i_in,
    pdw_out_if.source  o_out
);
    localparam int AW = pdw_pkg::ADDR_W;
    localparam int CW = pdw_pkg::CNT_W;
    localparam int XW = pdw_pkg::COORD_W;

    pdw_pkg::t_state r_state;
    pdw_pkg::t_state n_state;

    // The point store: one word per path point, packed as z, y, x.
    logic [pdw_pkg::POINT_W-1:0] r_mem [pdw_pkg::PATH_DEPTH];
    logic [pdw_pkg::POINT_W-1:0] r_rd_data;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_next;
    logic [CW-1:0] r_qi;
    logic [1:0]    r_k;

    logic signed [XW-1:0] r_last [3];
    logic signed [XW-1:0] r_pos  [3];
    logic signed [XW-1:0] r_p0   [3];
    logic signed [XW-1:0] r_p1   [3];
    logic [pdw_pkg::MAG_W-1:0]   r_dabs [3];
    logic [2:0]                  r_dneg;
    logic [pdw_pkg::DIST_W-1:0]  r_rem;
    logic [pdw_pkg::SUMSQ_W-1:0] r_sumsq;
    logic [pdw_pkg::LEN_W-1:0]   r_len;

    logic signed [XW-1:0] r_out_x;
    logic signed [XW-1:0] r_out_y;
    logic signed [XW-1:0] r_out_z;
    logic                 r_out_arrived;
    logic                 r_out_none;
    logic                 r_out_last;

    // Combinational controls decoded from the state.
    logic                        in_ready;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [pdw_pkg::POINT_W-1:0] wr_data;
    logic                        mul_start;
    logic [pdw_pkg::MAG_W-1:0]   mul_a;
    logic                        sqrt_start;
    logic                        div_start;

    logic                        mul_done;
    logic [pdw_pkg::PROD_W-1:0]  mul_product;
    logic                        sqrt_done;
    logic [pdw_pkg::LEN_W-1:0]   sqrt_root;
    logic                        div_done;
    logic [pdw_pkg::MAG_W-1:0]   div_quot;

    logic                        in_accept;
    logic                        out_accept;
    logic                        is_first;
    logic [CW-1:0]               load_base;
    logic signed [XW:0]          diff [3];
    logic [pdw_pkg::MAG_W-1:0]   offset;

    assign in_accept  = i_in.valid && in_ready;
    assign out_accept = o_out.valid && o_out.ready;
    assign is_first   = i_in.first_point;
    // A first point restarts the path, so it always lands at the bottom of the store.
    assign load_base  = is_first ? '0 : r_count;

    // Signed coordinate differences, one bit wider so that no span overflows.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = {r_p1[k][XW-1], r_p1[k]} - {r_p0[k][XW-1], r_p0[k]};
        end
    end

    // A zero-length segment takes ratio zero; the division result is then discarded.
    assign offset = (r_len == '0) ? '0 : div_quot;

    pdw_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (r_dabs[r_k]),
        .o_product (mul_product),
        .o_done    (mul_done)
    );

    pdw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_sumsq),
        .o_root  (sqrt_root),
        .o_done  (sqrt_done)
    );

    pdw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_product),
        .i_divisor  (r_len),
        .o_quot     (div_quot),
        .o_done     (div_done)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdw_pkg::ST_IDLE: begin
                if (in_accept && i_in.command == pdw_pkg::CMD_ADVANCE) begin
                    n_state = pdw_pkg::ST_SEG_CHECK;
                end else if (in_accept && i_in.command == pdw_pkg::CMD_QUERY) begin
                    n_state = pdw_pkg::ST_Q_CHECK;
                end
            end
            pdw_pkg::ST_SEG_CHECK: begin
                n_state = (r_next < r_count) ? pdw_pkg::ST_RD_P0 : pdw_pkg::ST_OUT;
            end
            pdw_pkg::ST_RD_P0: n_state = pdw_pkg::ST_RD_P1;
            pdw_pkg::ST_RD_P1: n_state = pdw_pkg::ST_DIFF;
            pdw_pkg::ST_DIFF:  n_state = pdw_pkg::ST_SQ_GO;
            pdw_pkg::ST_SQ_GO: n_state = pdw_pkg::ST_SQ_WAIT;
            pdw_pkg::ST_SQ_WAIT: begin
                if (mul_done) begin
                    n_state = (r_k == 2'd2) ? pdw_pkg::ST_ROOT_GO : pdw_pkg::ST_SQ_GO;
                end
            end
            pdw_pkg::ST_ROOT_GO: n_state = pdw_pkg::ST_ROOT_WAIT;
            pdw_pkg::ST_ROOT_WAIT: begin
                if (sqrt_done) begin
                    n_state = pdw_pkg::ST_DECIDE;
                end
            end
            pdw_pkg::ST_DECIDE: begin
                n_state = (r_len < pdw_pkg::LEN_W'(r_rem)) ? pdw_pkg::ST_SEG_CHECK
                                                          : pdw_pkg::ST_I_MUL_GO;
            end
            pdw_pkg::ST_I_MUL_GO: n_state = pdw_pkg::ST_I_MUL_WAIT;
            pdw_pkg::ST_I_MUL_WAIT: begin
                if (mul_done) begin
                    n_state = pdw_pkg::ST_I_DIV_GO;
                end
            end
            pdw_pkg::ST_I_DIV_GO: n_state = pdw_pkg::ST_I_DIV_WAIT;
            pdw_pkg::ST_I_DIV_WAIT: begin
                if (div_done) begin
                    n_state = (r_k == 2'd2) ? pdw_pkg::ST_WB : pdw_pkg::ST_I_MUL_GO;
                end
            end
            pdw_pkg::ST_WB:      n_state = pdw_pkg::ST_OUT;
            pdw_pkg::ST_Q_CHECK: begin
                n_state = (r_next < r_count) ? pdw_pkg::ST_Q_ISSUE : pdw_pkg::ST_OUT;
            end
            pdw_pkg::ST_Q_ISSUE: n_state = pdw_pkg::ST_Q_LOAD;
            pdw_pkg::ST_Q_LOAD:  n_state = pdw_pkg::ST_OUT;
            pdw_pkg::ST_OUT: begin
                if (out_accept) begin
                    n_state = r_out_last ? pdw_pkg::ST_IDLE : pdw_pkg::ST_Q_ISSUE;
                end
            end
            default: n_state = pdw_pkg::ST_IDLE;
        endcase
    end

    // Output and control decode.
    always_comb begin
        in_ready   = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_qi[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = load_base[AW-1:0];
        wr_data    = {i_in.point_z, i_in.point_y, i_in.point_x};
        mul_start  = 1'b0;
        mul_a      = r_dabs[r_k];
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        unique case (r_state)
            pdw_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                // Points beyond the store's capacity are dropped.
                wr_en = i_in.valid && i_in.command == pdw_pkg::CMD_LOAD &&
                        load_base < CW'(pdw_pkg::PATH_DEPTH);
            end
            pdw_pkg::ST_SEG_CHECK: begin
                rd_en   = 1'b1;
                rd_addr = AW'(r_next - 1'b1);
            end
            pdw_pkg::ST_RD_P0: begin
                rd_en   = 1'b1;
                rd_addr = r_next[AW-1:0];
            end
            pdw_pkg::ST_SQ_GO: begin
                mul_start = 1'b1;
            end
            pdw_pkg::ST_ROOT_GO: begin
                sqrt_start = 1'b1;
            end
            pdw_pkg::ST_I_MUL_GO: begin
                mul_start = 1'b1;
                mul_a     = pdw_pkg::MAG_W'(r_rem);
            end
            pdw_pkg::ST_I_DIV_GO: begin
                div_start = 1'b1;
            end
            pdw_pkg::ST_WB: begin
                // The interpolated position becomes the start of the current segment.
                wr_en   = 1'b1;
                wr_addr = AW'(r_next - 1'b1);
                wr_data = {r_pos[2], r_pos[1], r_pos[0]};
            end
            pdw_pkg::ST_Q_ISSUE: begin
                rd_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Path bookkeeping and the last reported position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_next  <= CW'(1);
            for (int k = 0; k < 3; k++) begin
                r_last[k] <= '0;
            end
        end else begin
            if (r_state == pdw_pkg::ST_IDLE && in_accept &&
                    i_in.command == pdw_pkg::CMD_LOAD) begin
                if (is_first) begin
                    r_next <= CW'(1);
                end
                if (load_base < CW'(pdw_pkg::PATH_DEPTH)) begin
                    r_count <= load_base + 1'b1;
                end else begin
                    r_count <= load_base;
                end
            end
            if (r_state == pdw_pkg::ST_DECIDE && r_len < pdw_pkg::LEN_W'(r_rem)) begin
                r_next <= r_next + 1'b1;
            end
            if ((r_state == pdw_pkg::ST_SEG_CHECK && !(r_next < r_count)) ||
                    r_state == pdw_pkg::ST_WB) begin
                r_last <= r_pos;
            end
        end
    end

    // Datapath of the walk and the output word register.
    always_ff @(posedge i_clk) begin
        if (r_state == pdw_pkg::ST_IDLE && in_accept) begin
            r_rem <= i_in.step_distance;
            r_pos <= r_last;
        end
        if (r_state == pdw_pkg::ST_RD_P0) begin
            r_p0[0] <= r_rd_data[XW-1:0];
            r_p0[1] <= r_rd_data[2*XW-1:XW];
            r_p0[2] <= r_rd_data[3*XW-1:2*XW];
        end
        if (r_state == pdw_pkg::ST_RD_P1) begin
            r_p1[0] <= r_rd_data[XW-1:0];
            r_p1[1] <= r_rd_data[2*XW-1:XW];
            r_p1[2] <= r_rd_data[3*XW-1:2*XW];
        end
        if (r_state == pdw_pkg::ST_DIFF) begin
            for (int k = 0; k < 3; k++) begin
                r_dneg[k] <= diff[k][XW];
                r_dabs[k] <= diff[k][XW] ? pdw_pkg::MAG_W'(-diff[k])
                                         : pdw_pkg::MAG_W'(diff[k]);
            end
            r_sumsq <= '0;
            r_k     <= 2'd0;
        end
        if (r_state == pdw_pkg::ST_SQ_WAIT && mul_done) begin
            r_sumsq <= r_sumsq + pdw_pkg::SUMSQ_W'(mul_product);
            r_k     <= r_k + 2'd1;
        end
        if (r_state == pdw_pkg::ST_ROOT_WAIT && sqrt_done) begin
            r_len <= sqrt_root;
        end
        if (r_state == pdw_pkg::ST_DECIDE) begin
            r_k <= 2'd0;
            if (r_len < pdw_pkg::LEN_W'(r_rem)) begin
                // The whole segment fits in the distance left: jump to its end.
                r_rem <= r_rem - pdw_pkg::DIST_W'(r_len);
                r_pos <= r_p1;
            end
        end
        if (r_state == pdw_pkg::ST_I_DIV_WAIT && div_done) begin
            r_pos[r_k] <= r_dneg[r_k] ? r_p0[r_k] - XW'(offset) : r_p0[r_k] + XW'(offset);
            r_k        <= r_k + 2'd1;
        end
        if ((r_state == pdw_pkg::ST_SEG_CHECK && !(r_next < r_count)) ||
                r_state == pdw_pkg::ST_WB) begin
            r_out_x       <= r_pos[0];
            r_out_y       <= r_pos[1];
            r_out_z       <= r_pos[2];
            r_out_arrived <= !(r_next < r_count);
            r_out_none    <= 1'b0;
            r_out_last    <= 1'b1;
        end
        if (r_state == pdw_pkg::ST_Q_CHECK) begin
            r_qi          <= r_next;
            r_out_x       <= '0;
            r_out_y       <= '0;
            r_out_z       <= '0;
            r_out_arrived <= 1'b0;
            r_out_none    <= 1'b1;
            r_out_last    <= 1'b1;
        end
        if (r_state == pdw_pkg::ST_Q_LOAD) begin
            r_out_x       <= r_rd_data[XW-1:0];
            r_out_y       <= r_rd_data[2*XW-1:XW];
            r_out_z       <= r_rd_data[3*XW-1:2*XW];
            r_out_arrived <= 1'b0;
            r_out_none    <= 1'b0;
            r_out_last    <= (r_qi + 1'b1 == r_count);
        end
        if (r_state == pdw_pkg::ST_OUT && out_accept) begin
            r_qi <= r_qi + 1'b1;
        end
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = (r_state == pdw_pkg::ST_OUT);
    assign o_out.pos_x     = r_out_x;
    assign o_out.pos_y     = r_out_y;
    assign o_out.pos_z     = r_out_z;
    assign o_out.arrived   = r_out_arrived;
    assign o_out.none_left = r_out_none;
    assign o_out.last      = r_out_last;

    // The next-segment index stays between one and one past the point count.
    a_next_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next != '0 && r_next <= r_count + 1'b1)
        else $error("next segment index out of range");

    // The point count never exceeds the store's depth.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(pdw_pkg::PATH_DEPTH))
        else $error("point count beyond store depth");

    // A multiplier result only arrives while the sequencer is waiting for one.
    a_mul_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == pdw_pkg::ST_SQ_WAIT || r_state == pdw_pkg::ST_I_MUL_WAIT))
        else $error("multiplier finished outside a wait state");

    // The divider is only launched after a multiplication has finished.
    a_div_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> $past(r_state) == pdw_pkg::ST_I_MUL_WAIT)
        else $error("divider launched without a product");
endmodule

// ===== rtl/pdw_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle.
module pdw_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pdw_pkg::MAG_W-1:0]     i_a,
    input  logic [pdw_pkg::MAG_W-1:0]     i_b,
    output logic [pdw_pkg::PROD_W-1:0]    o_product,
    output logic                          o_done
);
    localparam int CW = $clog2(pdw_pkg::MUL_STEPS + 1);

    logic                       r_busy;
    logic                       r_done;
    logic [CW-1:0]              r_cnt;
    logic [pdw_pkg::PROD_W-1:0] r_acc;
    logic [pdw_pkg::PROD_W-1:0] r_mcand;
    logic [pdw_pkg::MAG_W-1:0]  r_mplier;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(pdw_pkg::MUL_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= pdw_pkg::PROD_W'(i_a);
            r_mplier <= i_b;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_product = r_acc;
    assign o_done    = r_done;
endmodule

// ===== rtl/pdw_sqrt.sv =====
// Restoring integer square root, one root bit per cycle.
module pdw_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pdw_pkg::SUMSQ_W-1:0]   i_rad,
    output logic [pdw_pkg::LEN_W-1:0]     o_root,
    output logic                          o_done
);
    localparam int CW = $clog2(pdw_pkg::ROOT_STEPS + 1);
    localparam int RW = pdw_pkg::LEN_W + 1;

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [pdw_pkg::SUMSQ_W-1:0] r_rad;
    logic [RW-1:0]               r_rem;
    logic [pdw_pkg::LEN_W-1:0]   r_root;
    logic [RW+1:0]               n_shift;
    logic [RW+1:0]               n_trial;

    always_comb begin
        n_shift = {r_rem, r_rad[pdw_pkg::SUMSQ_W-1 -: 2]};
        n_trial = {1'b0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(pdw_pkg::ROOT_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= r_rad << 2;
            if (n_shift >= n_trial) begin
                r_rem  <= RW'(n_shift - n_trial);
                r_root <= {r_root[pdw_pkg::LEN_W-2:0], 1'b1};
            end else begin
                r_rem  <= RW'(n_shift);
                r_root <= {r_root[pdw_pkg::LEN_W-2:0], 1'b0};
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;
endmodule

// ===== rtl/pdw_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pdw_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pdw_pkg::PROD_W-1:0]    i_dividend,
    input  logic [pdw_pkg::LEN_W-1:0]     i_divisor,
    output logic [pdw_pkg::MAG_W-1:0]     o_quot,
    output logic                          o_done
);
    localparam int CW = $clog2(pdw_pkg::DIV_STEPS + 1);
    localparam int DW = pdw_pkg::LEN_W;

    logic                       r_busy;
    logic                       r_done;
    logic [CW-1:0]              r_cnt;
    logic [pdw_pkg::PROD_W-1:0] r_dq;
    logic [DW-1:0]              r_rem;
    logic [DW-1:0]              r_dvs;
    logic [DW:0]                n_shift;

    assign n_shift = {r_rem, r_dq[pdw_pkg::PROD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(pdw_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (n_shift >= {1'b0, r_dvs}) begin
                r_rem <= DW'(n_shift - {1'b0, r_dvs});
                r_dq  <= {r_dq[pdw_pkg::PROD_W-2:0], 1'b1};
            end else begin
                r_rem <= DW'(n_shift);
                r_dq  <= {r_dq[pdw_pkg::PROD_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_dq[pdw_pkg::MAG_W-1:0];
    assign o_done = r_done;
endmodule
